/* design/gbts_pkg.sv */
// Shared operation codes, field widths and controller/datapath link types.
`default_nettype none
package gbts_pkg;

   // Field widths of the request and response channels.
   localparam int OP_W     = 3;
   localparam int AMOUNT_W = 13;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 12;
   localparam int LEN_W    = 13;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOAD_BEGIN   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT_BEGIN = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT_BYTE  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE_BACK  = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE_FWD   = 3'd4;
   localparam logic [OP_W-1:0] OP_MOVE_LEFT    = 3'd5;
   localparam logic [OP_W-1:0] OP_MOVE_RIGHT   = 3'd6;
   localparam logic [OP_W-1:0] OP_READ_AT      = 3'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic move_read;
      logic move_fail;
      logic move_write;
      logic read_capture;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            count_zero;
      logic            at_boundary;
   } sts_type;

endpackage
`default_nettype wire

/* design/gbts_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface gbts_req_if;
   import gbts_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [AMOUNT_W-1:0] amount;
   logic [BYTE_W-1:0]   byte_value;
   logic [POS_W-1:0]    position;

   modport source (output valid, output operation, output amount, output byte_value,
                   output position, input ready);
   modport sink (input valid, input operation, input amount, input byte_value,
                 input position, output ready);
endinterface

interface gbts_rsp_if;
   import gbts_pkg::*;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [BYTE_W-1:0] read_byte;
   logic [LEN_W-1:0]  cursor_pos;
   logic [LEN_W-1:0]  text_length;
   logic [LEN_W-1:0]  right_length;

   modport source (output valid, output ok, output read_byte, output cursor_pos,
                   output text_length, output right_length, input ready);
   modport sink (input valid, input ok, input read_byte, input cursor_pos,
                 input text_length, input right_length, output ready);
endinterface
`default_nettype wire

/* design/gap_buffer_text_store_core.sv */
// Top level of the gap-buffer text store.
// The block keeps up to CAPACITY bytes of text in one single-port-write memory, split
// around a gap at the cursor, and answers every request with one response giving the
// status, the byte read and the cursor and length figures after the request. Requests
// are handled one at a time. Load, insert, delete and insert-byte requests pass through
// the execute and done states to the response register; read-at adds a wait state, as the
// memory read data is registered; a move repeats a read state and a write state per byte,
// reading each byte from one side of the gap and writing it to the other.
// A new request is accepted while the previous response still waits in the output
// register. The memory content is not cleared at reset and needs no clearing pass.
`default_nettype none
module gap_buffer_text_store_core #(
   parameter int CAPACITY = 4096
) (
   input  logic       clock,
   input  logic       reset,
   gbts_req_if.sink   req_if,
   gbts_rsp_if.source rsp_if
);
   import gbts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each request.
   gbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Gap pointers, text memory and response register.
   gbts_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_if.operation),
      .req_amount       (req_if.amount),
      .req_byte_value   (req_if.byte_value),
      .req_position     (req_if.position),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ok           (rsp_if.ok),
      .rsp_read_byte    (rsp_if.read_byte),
      .rsp_cursor_pos   (rsp_if.cursor_pos),
      .rsp_text_length  (rsp_if.text_length),
      .rsp_right_length (rsp_if.right_length)
   );

endmodule
`default_nettype wire

/* design/gbts_ctrl.sv */
// Controller state machine sequencing each request through the datapath.
`default_nettype none
module gbts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  gbts_pkg::sts_type sts,
   output gbts_pkg::cmd_type cmd
);
   import gbts_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_EXEC      = 3'd1;
   localparam logic [2:0] ST_READ_WAIT = 3'd2;
   localparam logic [2:0] ST_MOVE_RD   = 3'd3;
   localparam logic [2:0] ST_MOVE_WR   = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.op == OP_MOVE_LEFT || sts.op == OP_MOVE_RIGHT) begin
               state_in = ST_MOVE_RD;
            end else if (sts.op == OP_READ_AT) begin
               state_in = ST_READ_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_DONE;
         end
         ST_MOVE_RD: begin
            if (sts.count_zero) begin
               state_in = ST_DONE;
            end else if (sts.at_boundary) begin
               cmd.move_fail = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.move_read = 1'b1;
               state_in      = ST_MOVE_WR;
            end
         end
         ST_MOVE_WR: begin
            cmd.move_write = 1'b1;
            state_in       = ST_MOVE_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid flag of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* design/gbts_datapath.sv */
// Datapath: gap pointers, text memory, request latch and response register.
`default_nettype none
module gbts_datapath #(
   parameter int CAPACITY = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gbts_pkg::OP_W-1:0]     req_operation,
   input  logic [gbts_pkg::AMOUNT_W-1:0] req_amount,
   input  logic [gbts_pkg::BYTE_W-1:0]   req_byte_value,
   input  logic [gbts_pkg::POS_W-1:0]    req_position,
   input  gbts_pkg::cmd_type             cmd,
   output gbts_pkg::sts_type             sts,
   output logic                          rsp_ok,
   output logic [gbts_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic [gbts_pkg::LEN_W-1:0]    rsp_cursor_pos,
   output logic [gbts_pkg::LEN_W-1:0]    rsp_text_length,
   output logic [gbts_pkg::LEN_W-1:0]    rsp_right_length
);
   import gbts_pkg::*;

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = (PW > AMOUNT_W) ? PW : AMOUNT_W;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
   localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

   // Gap pointers and pending run length.
   logic [PW-1:0]       gap_start_ff, gap_start_in;
   logic [PW-1:0]       gap_end_ff, gap_end_in;
   logic [AMOUNT_W-1:0] pending_ff, pending_in;

   // Latched request and per-request results.
   logic [OP_W-1:0]     op_ff, op_in;
   logic [AMOUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                ok_ff, ok_in;
   logic [BYTE_W-1:0]   rd_byte_ff, rd_byte_in;
   logic                in_range_ff, in_range_in;

   // Response register.
   logic                rsp_ok_ff;
   logic [BYTE_W-1:0]   rsp_read_byte_ff;
   logic [LEN_W-1:0]    rsp_cursor_ff, rsp_length_ff, rsp_right_ff;

   // Text memory.
   logic [BYTE_W-1:0]   mem [CAPACITY];
   logic [BYTE_W-1:0]   rdata_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [BYTE_W-1:0]   mem_wdata;

   // Arithmetic on the gap pointers in a common width.
   logic [XW-1:0] gs_x, ge_x, amt_x, pos_x, len_x, right_x, gap_x, idx_x;
   logic [PW-1:0] gs_m1, ge_m1;
   logic          move_left;

   assign gs_x    = XW'(gap_start_ff);
   assign ge_x    = XW'(gap_end_ff);
   assign amt_x   = XW'(count_ff);
   assign pos_x   = XW'(pos_ff);
   assign right_x = CAP_X - ge_x;
   assign len_x   = gs_x + right_x;
   assign gap_x   = ge_x - gs_x;
   assign idx_x   = (pos_x < gs_x) ? pos_x : pos_x + gap_x;
   assign gs_m1   = gap_start_ff - PW'(1);
   assign ge_m1   = gap_end_ff - PW'(1);
   assign move_left = (op_ff == OP_MOVE_LEFT);

   assign sts.op          = op_ff;
   assign sts.count_zero  = (count_ff == '0);
   assign sts.at_boundary = move_left ? (gap_start_ff == '0) : (gap_end_ff >= CAP_P);

   // Next values of the datapath registers and memory controls.
   always_comb begin
      gap_start_in = gap_start_ff;
      gap_end_in   = gap_end_ff;
      pending_in   = pending_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      ok_in        = ok_ff;
      rd_byte_in   = rd_byte_ff;
      in_range_in  = in_range_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = gap_start_ff[AW-1:0];
      mem_wdata    = byte_ff;
      mem_raddr    = idx_x[AW-1:0];

      if (cmd.load_req) begin
         op_in      = req_operation;
         count_in   = req_amount;
         byte_in    = req_byte_value;
         pos_in     = req_position;
         ok_in      = 1'b1;
         rd_byte_in = '0;
      end

      if (cmd.exec) begin
         case (op_ff)
            OP_LOAD_BEGIN: begin
               if (amt_x > CAP_X) begin
                  ok_in = 1'b0;
               end else begin
                  gap_start_in = '0;
                  gap_end_in   = CAP_P;
                  pending_in   = count_ff;
               end
            end
            OP_INSERT_BEGIN: begin
               if (gap_x < amt_x) begin
                  ok_in = 1'b0;
               end else begin
                  pending_in = count_ff;
               end
            end
            OP_INSERT_BYTE: begin
               if (pending_ff == '0 || gap_start_ff >= gap_end_ff) begin
                  ok_in = 1'b0;
               end else begin
                  mem_we       = 1'b1;
                  gap_start_in = gap_start_ff + PW'(1);
                  pending_in   = pending_ff - AMOUNT_W'(1);
               end
            end
            OP_DELETE_BACK: begin
               pending_in = '0;
               if (amt_x > gs_x) begin
                  ok_in = 1'b0;
               end else begin
                  gap_start_in = PW'(gs_x - amt_x);
               end
            end
            OP_DELETE_FWD: begin
               pending_in = '0;
               if (amt_x > right_x) begin
                  ok_in = 1'b0;
               end else begin
                  gap_end_in = PW'(ge_x + amt_x);
               end
            end
            OP_MOVE_LEFT, OP_MOVE_RIGHT: begin
               pending_in = '0;
            end
            OP_READ_AT: begin
               mem_re      = 1'b1;
               in_range_in = (pos_x < len_x);
            end
            default: begin
               ok_in = ok_ff;
            end
         endcase
      end

      // One byte of a move: read the source, then write it across the gap.
      if (cmd.move_read) begin
         mem_re    = 1'b1;
         mem_raddr = move_left ? gs_m1[AW-1:0] : gap_end_ff[AW-1:0];
      end
      if (cmd.move_fail) begin
         ok_in = 1'b0;
      end
      if (cmd.move_write) begin
         mem_we    = 1'b1;
         mem_wdata = rdata_ff;
         count_in  = count_ff - AMOUNT_W'(1);
         if (move_left) begin
            mem_waddr    = ge_m1[AW-1:0];
            gap_start_in = gs_m1;
            gap_end_in   = ge_m1;
         end else begin
            mem_waddr    = gap_start_ff[AW-1:0];
            gap_start_in = gap_start_ff + PW'(1);
            gap_end_in   = gap_end_ff + PW'(1);
         end
      end

      if (cmd.read_capture) begin
         rd_byte_in = in_range_ff ? rdata_ff : '0;
      end
   end

   // Gap state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_start_ff <= '0;
         gap_end_ff   <= CAP_P;
         pending_ff   <= '0;
      end else begin
         gap_start_ff <= gap_start_in;
         gap_end_ff   <= gap_end_in;
         pending_ff   <= pending_in;
      end
   end

   // Request latch and working results.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      count_ff    <= count_in;
      byte_ff     <= byte_in;
      pos_ff      <= pos_in;
      ok_ff       <= ok_in;
      rd_byte_ff  <= rd_byte_in;
      in_range_ff <= in_range_in;
   end

   // Text memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Response register, loaded once the request has finished.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ok_ff        <= ok_ff;
         rsp_read_byte_ff <= rd_byte_ff;
         rsp_cursor_ff    <= gs_x[LEN_W-1:0];
         rsp_length_ff    <= len_x[LEN_W-1:0];
         rsp_right_ff     <= right_x[LEN_W-1:0];
      end
   end

   assign rsp_ok           = rsp_ok_ff;
   assign rsp_read_byte    = rsp_read_byte_ff;
   assign rsp_cursor_pos   = rsp_cursor_ff;
   assign rsp_text_length  = rsp_length_ff;
   assign rsp_right_length = rsp_right_ff;

endmodule
`default_nettype wire

/* dv/gbts_tb_pkg.sv */
// Request predictor and response scoreboard for the gap-buffer text store testbench.
`timescale 1ns / 100ps
package gbts_tb_pkg;
   import gbts_pkg::*;

   localparam int unsigned TB_CAPACITY = 4096;

   // One expected response, tagged with the operation that caused it.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              ok;
      logic [BYTE_W-1:0] read_byte;
      logic [LEN_W-1:0]  cursor_pos;
      logic [LEN_W-1:0]  text_length;
      logic [LEN_W-1:0]  right_length;
   } edit_result_type;

   class text_store_scoreboard;
      logic [BYTE_W-1:0] text_copy [TB_CAPACITY];
      int unsigned       gap_lo;
      int unsigned       gap_hi;
      int unsigned       run_left;
      edit_result_type   awaited_q [$];
      int unsigned       mismatches;

      function new();
         gap_lo     = 0;
         gap_hi     = TB_CAPACITY;
         run_left   = 0;
         mismatches = 0;
      endfunction

      function int unsigned outstanding();
         return awaited_q.size();
      endfunction

      // Applies one accepted request to the shadow text and queues the response it should give.
      function void note_request(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount,
                                 input logic [BYTE_W-1:0] value, input logic [POS_W-1:0] pos);
         edit_result_type res;
         int unsigned     n;
         int unsigned     len;
         int unsigned     idx;
         int unsigned     step;
         res    = '0;
         res.op = op;
         res.ok = 1'b1;
         n      = amount;
         case (op)
            OP_LOAD_BEGIN: begin
               if (n > TB_CAPACITY) begin
                  res.ok = 1'b0;
               end else begin
                  gap_lo   = 0;
                  gap_hi   = TB_CAPACITY;
                  run_left = n;
               end
            end
            OP_INSERT_BEGIN: begin
               if (gap_hi - gap_lo < n) begin
                  res.ok = 1'b0;
               end else begin
                  run_left = n;
               end
            end
            OP_INSERT_BYTE: begin
               // A byte only lands while an announced run lasts and the gap has room.
               if (run_left == 0 || gap_lo >= gap_hi) begin
                  res.ok = 1'b0;
               end else begin
                  text_copy[gap_lo] = value;
                  gap_lo++;
                  run_left--;
               end
            end
            OP_DELETE_BACK: begin
               run_left = 0;
               if (n > gap_lo) begin
                  res.ok = 1'b0;
               end else begin
                  gap_lo -= n;
               end
            end
            OP_DELETE_FWD: begin
               run_left = 0;
               if (n > TB_CAPACITY - gap_hi) begin
                  res.ok = 1'b0;
               end else begin
                  gap_hi += n;
               end
            end
            OP_MOVE_LEFT: begin
               // Steps made before hitting the start of the text are kept.
               run_left = 0;
               for (step = 0; step < n; step++) begin
                  if (gap_lo == 0) begin
                     res.ok = 1'b0;
                     break;
                  end
                  gap_hi--;
                  gap_lo--;
                  text_copy[gap_hi] = text_copy[gap_lo];
               end
            end
            OP_MOVE_RIGHT: begin
               run_left = 0;
               for (step = 0; step < n; step++) begin
                  if (gap_hi >= TB_CAPACITY) begin
                     res.ok = 1'b0;
                     break;
                  end
                  text_copy[gap_lo] = text_copy[gap_hi];
                  gap_hi++;
                  gap_lo++;
               end
            end
            OP_READ_AT: begin
               // Logical positions behind the cursor skip over the gap.
               len = gap_lo + (TB_CAPACITY - gap_hi);
               if (pos < len) begin
                  idx           = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo);
                  res.read_byte = text_copy[idx];
               end
            end
            default: begin
            end
         endcase
         res.cursor_pos   = LEN_W'(gap_lo);
         res.text_length  = LEN_W'(gap_lo + (TB_CAPACITY - gap_hi));
         res.right_length = LEN_W'(TB_CAPACITY - gap_hi);
         awaited_q.push_back(res);
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Compares an accepted response with the oldest outstanding expectation.
      task check_response(input logic ok, input logic [BYTE_W-1:0] read_byte,
                          input logic [LEN_W-1:0] cursor_pos, input logic [LEN_W-1:0] text_length,
                          input logic [LEN_W-1:0] right_length);
         edit_result_type want;
         if (awaited_q.size() == 0) begin
            report_mismatch($sformatf("response with none outstanding: ok %0b cursor %0d",
                                      ok, cursor_pos));
         end else begin
            want = awaited_q.pop_front();
            if (ok !== want.ok)
               report_mismatch($sformatf("op %0d ok: got %0b, expected %0b",
                                         want.op, ok, want.ok));
            if (read_byte !== want.read_byte)
               report_mismatch($sformatf("op %0d read_byte: got %0h, expected %0h",
                                         want.op, read_byte, want.read_byte));
            if (cursor_pos !== want.cursor_pos)
               report_mismatch($sformatf("op %0d cursor_pos: got %0d, expected %0d",
                                         want.op, cursor_pos, want.cursor_pos));
            if (text_length !== want.text_length)
               report_mismatch($sformatf("op %0d text_length: got %0d, expected %0d",
                                         want.op, text_length, want.text_length));
            if (right_length !== want.right_length)
               report_mismatch($sformatf("op %0d right_length: got %0d, expected %0d",
                                         want.op, right_length, want.right_length));
         end
      endtask
   endclass

endpackage

/* dv/testbench.sv */
// Top-level testbench: drives requests into the gap-buffer text store and checks every response.
`timescale 1ns / 100ps
module testbench;
   import gbts_pkg::*;
   import gbts_tb_pkg::*;

   localparam int unsigned RUN_LIMIT = 5_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        quiet = 1'b0;
   logic        pressure_done = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned responses_seen = 0;

   text_store_scoreboard sb = new();

   gbts_req_if req_if ();
   gbts_rsp_if rsp_if ();

   gap_buffer_text_store_core #(
      .CAPACITY(TB_CAPACITY)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.operation, req_if.amount, req_if.byte_value, req_if.position);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.ok, rsp_if.read_byte, rsp_if.cursor_pos,
                              rsp_if.text_length, rsp_if.right_length);
            responses_seen++;
         end
      end
   end

   // Response side: short random stalls, plus one long hold-off that backs up the block.
   initial begin : response_sink
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!pressure_done && responses_seen >= 100) begin
            pressure_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Offers one request from a falling edge and returns on the falling edge after acceptance.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount,
                               input logic [BYTE_W-1:0] value, input logic [POS_W-1:0] pos);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.operation  <= op;
      req_if.amount     <= amount;
      req_if.byte_value <= value;
      req_if.position   <= pos;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Picks one request, mostly well-formed edits sized to the current text.
   task automatic random_request();
      int unsigned     pick;
      int unsigned     left;
      int unsigned     right;
      int unsigned     len;
      int unsigned     amount;
      int unsigned     pos;
      logic [OP_W-1:0] op;
      left   = sb.gap_lo;
      right  = TB_CAPACITY - sb.gap_hi;
      len    = left + right;
      pick   = $urandom_range(0, 99);
      amount = $urandom_range(0, TB_CAPACITY);
      pos    = $urandom_range(0, TB_CAPACITY - 1);
      if (sb.run_left != 0 && len < 300 && pick < 85) begin
         op = OP_INSERT_BYTE;
      end else if (pick < 6) begin
         op = OP_LOAD_BEGIN;
         if ($urandom_range(0, 9) != 0) amount = $urandom_range(0, 40);
      end else if (pick < 18) begin
         op = OP_INSERT_BEGIN;
         if ($urandom_range(0, 9) != 0)
            amount = (len < 150) ? $urandom_range(1, 30) : $urandom_range(0, 2);
      end else if (pick < 23) begin
         op = OP_INSERT_BYTE;
      end else if (pick < 33) begin
         op = OP_DELETE_BACK;
         if ($urandom_range(0, 19) != 0) amount = $urandom_range(0, left + 2);
      end else if (pick < 43) begin
         op = OP_DELETE_FWD;
         if ($urandom_range(0, 19) != 0) amount = $urandom_range(0, right + 2);
      end else if (pick < 55) begin
         op = OP_MOVE_LEFT;
         if ($urandom_range(0, 29) != 0) amount = $urandom_range(0, left + 3);
      end else if (pick < 67) begin
         op = OP_MOVE_RIGHT;
         if ($urandom_range(0, 29) != 0) amount = $urandom_range(0, right + 3);
      end else begin
         op = OP_READ_AT;
         if ($urandom_range(0, 4) != 0) pos = $urandom_range(0, len + 2) % TB_CAPACITY;
      end
      send_request(op, AMOUNT_W'(amount), BYTE_W'($urandom_range(0, 255)), POS_W'(pos));
   endtask

   // Main sequence: reset, directed edge cases, random edits, then a cursor sweep pass.
   initial begin : stimulus
      int unsigned k;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_READ_AT;
      req_if.amount     = '0;
      req_if.byte_value = '0;
      req_if.position   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty text, stray byte, over-long loads, then a short run with extreme bytes.
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'h77, 12'd0);
      send_request(OP_LOAD_BEGIN, 13'd8191, 8'd0, 12'd0);
      send_request(OP_LOAD_BEGIN, 13'd4097, 8'd0, 12'd0);
      send_request(OP_LOAD_BEGIN, 13'd4, 8'd0, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'h00, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'hFF, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'hA5, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'h5A, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'h11, 12'd0);
      // Insert longer than the gap, then a run abandoned by a move.
      send_request(OP_INSERT_BEGIN, 13'd8191, 8'd0, 12'd0);
      send_request(OP_INSERT_BEGIN, 13'd2, 8'd0, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'h3C, 12'd0);
      send_request(OP_MOVE_LEFT, 13'd2, 8'd0, 12'd0);
      send_request(OP_INSERT_BYTE, 13'd0, 8'hC3, 12'd0);
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd0);
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd3);
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd4095);
      // Move stopped at the end of the text, delete overruns on both sides.
      send_request(OP_MOVE_RIGHT, 13'd5, 8'd0, 12'd0);
      send_request(OP_DELETE_BACK, 13'd6, 8'd0, 12'd0);
      send_request(OP_DELETE_BACK, 13'd1, 8'd0, 12'd0);
      send_request(OP_MOVE_LEFT, 13'd1, 8'd0, 12'd0);
      send_request(OP_DELETE_FWD, 13'd2, 8'd0, 12'd0);
      send_request(OP_DELETE_FWD, 13'd1, 8'd0, 12'd0);
      send_request(OP_MOVE_RIGHT, 13'd0, 8'd0, 12'd0);
      send_request(OP_LOAD_BEGIN, 13'd4096, 8'd0, 12'd0);

      // Random edits; every fourth block of a hundred runs without stalls.
      for (k = 0; k < 900; k++) begin
         quiet = ((k / 100) % 4 == 3);
         random_request();
      end

      // Load a short text, hit the stray-byte case, sweep the cursor and trim both sides.
      quiet = 1'b1;
      send_request(OP_LOAD_BEGIN, 13'd48, 8'd0, 12'd0);
      for (k = 0; k < 48; k++)
         send_request(OP_INSERT_BYTE, AMOUNT_W'($urandom_range(0, TB_CAPACITY)),
                      BYTE_W'($urandom_range(0, 255)),
                      POS_W'($urandom_range(0, TB_CAPACITY - 1)));
      send_request(OP_INSERT_BYTE, 13'd0, 8'hFF, 12'd0);
      send_request(OP_INSERT_BEGIN, 13'd1, 8'd0, 12'd0);
      send_request(OP_INSERT_BEGIN, 13'd0, 8'd0, 12'd0);
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd4095);
      send_request(OP_MOVE_LEFT, 13'd4096, 8'd0, 12'd0);
      send_request(OP_MOVE_LEFT, 13'd1, 8'd0, 12'd0);
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd0);
      for (k = 0; k < 8; k++)
         send_request(OP_READ_AT, 13'd0, 8'd0, POS_W'($urandom_range(0, 63)));
      send_request(OP_MOVE_RIGHT, 13'd20, 8'd0, 12'd0);
      for (k = 0; k < 8; k++)
         send_request(OP_READ_AT, 13'd0, 8'd0, POS_W'($urandom_range(0, 63)));
      send_request(OP_DELETE_FWD, 13'd4096, 8'd0, 12'd0);
      send_request(OP_DELETE_FWD, 13'd28, 8'd0, 12'd0);
      send_request(OP_DELETE_BACK, 13'd20, 8'd0, 12'd0);
      send_request(OP_READ_AT, 13'd0, 8'd0, 12'd0);
      req_if.valid <= 1'b0;

      // Drain, then keep watching for any stray response before the verdict.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/gbts_pkg.sv
design/gbts_if.sv
design/gbts_ctrl.sv
design/gbts_datapath.sv
design/gap_buffer_text_store_core.sv
dv/gbts_tb_pkg.sv
dv/testbench.sv
